// ===== rtl/core/zfg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfg_pkg
// Constants, symbol tables and shared types for the frame to GFSK encoder.
// ----------------------------------------------------------------------------
package zfg_pkg;

	localparam int MAX_PAYLOAD    = 125;
	localparam int PREAMBLE_BYTES = 4;

	localparam int BYTE_W  = 8;
	localparam int LEFT_W  = 7;
	localparam int NIB_W   = 4;
	localparam int WORD_W  = 16;
	localparam int DIST_W  = 6;
	localparam int NSYM    = 16;
	localparam int CHIPS   = 32;

	localparam logic [BYTE_W-1:0] SFD_RESET = 8'hA7;
	localparam logic [BYTE_W-1:0] LEN_MAX   = BYTE_W'(MAX_PAYLOAD);
	localparam logic [15:0]       CRC_POLY  = 16'h8408;
	localparam logic [DIST_W-1:0] DIST_INIT = 6'd63;

	// status codes on the symbol channel
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_LEN = 1'b1;

	// symbol -> GFSK word, bit 0 sent first
	localparam logic [WORD_W-1:0] WORD_TABLE [NSYM] = '{
		16'h419F, 16'h0E77, 16'h999E, 16'h667A,
		16'h9DC3, 16'h770E, 16'hDC39, 16'h70E7,
		16'hBCF5, 16'hB3D7, 16'hCD5F, 16'h357F,
		16'hD5FC, 16'h57F3, 16'h5BCF, 16'h6F3D
	};

	// reference chip sequences, chip 0 is the MSB of each literal
	localparam logic [CHIPS-1:0] CHIP_SEQ [NSYM] = '{
		32'b11011001110000110101001000101110,
		32'b11101101100111000011010100100010,
		32'b00101110110110011100001101010010,
		32'b00100010111011011001110000110101,
		32'b01010010001011101101100111000011,
		32'b00110101001000101110110110011100,
		32'b11000011010100100010111011011001,
		32'b10011100001101010010001011101101,
		32'b10001100100101100000011101111011,
		32'b10111000110010010110000001110111,
		32'b01111011100011001001011000000111,
		32'b01110111101110001100100101100000,
		32'b00000111011110111000110010010110,
		32'b01100000011101111011100011001001,
		32'b10010110000001110111101110001100,
		32'b11001001011000000111011110111000
	};

	typedef logic [NSYM-1:0][DIST_W-1:0] dist_tab_t;

	// nearest-reference search, evaluated at elaboration only
	function automatic dist_tab_t build_dist();
		dist_tab_t t;
		int d;
		int best;
		for (int s = 0; s < NSYM; s++) begin
			best = CHIPS + 1;
			for (int r = 0; r < NSYM; r++) begin
				d = 0;
				for (int c = 0; c < CHIPS; c++) begin
					if (WORD_TABLE[s][c >> 1] != CHIP_SEQ[r][CHIPS-1-c])
						d++;
				end
				if (d < best)
					best = d;
			end
			t[s] = DIST_W'(best);
		end
		return t;
	endfunction

	function automatic logic [NSYM-1:0] build_match();
		logic [NSYM-1:0] m;
		int d;
		int best;
		int best_ref;
		for (int s = 0; s < NSYM; s++) begin
			best = CHIPS + 1;
			best_ref = 0;
			for (int r = 0; r < NSYM; r++) begin
				d = 0;
				for (int c = 0; c < CHIPS; c++) begin
					if (WORD_TABLE[s][c >> 1] != CHIP_SEQ[r][CHIPS-1-c])
						d++;
				end
				if (d < best) begin
					best = d;
					best_ref = r;
				end
			end
			m[s] = (best_ref == s);
		end
		return m;
	endfunction

	localparam dist_tab_t       DIST_TABLE  = build_dist();
	localparam logic [NSYM-1:0] MATCH_TABLE = build_match();

	// one symbol request from the frame sequencer to the symbol encoder
	typedef struct packed {
		logic             err;
		logic             first_sym;
		logic             frame_end;
		logic [NIB_W-1:0] nibble;
	} sym_req_t;

endpackage

// ===== rtl/core/zfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfg_if
// Valid/ready channels: payload beats in, symbol beats out.
// ----------------------------------------------------------------------------
interface zfg_in_if
	import zfg_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] payload_byte;
	logic [BYTE_W-1:0] payload_length;

	modport source (output valid, output payload_byte, output payload_length, input ready);
	modport sink (input valid, input payload_byte, input payload_length, output ready);
endinterface

interface zfg_out_if
	import zfg_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] gfsk_word;
	logic [NIB_W-1:0]  zigbee_symbol;
	logic [DIST_W-1:0] symbol_distance;
	logic              symbol_match;
	logic              frame_end;
	logic              frame_ok;
	logic [DIST_W-1:0] frame_dist_min;
	logic [DIST_W-1:0] frame_dist_max;
	logic              status;

	modport source (
		output valid, output gfsk_word, output zigbee_symbol, output symbol_distance,
		output symbol_match, output frame_end, output frame_ok, output frame_dist_min,
		output frame_dist_max, output status, input ready
	);
	modport sink (
		input valid, input gfsk_word, input zigbee_symbol, input symbol_distance,
		input symbol_match, input frame_end, input frame_ok, input frame_dist_min,
		input frame_dist_max, input status, output ready
	);
endinterface

// ===== rtl/core/zigbee_frame_to_gfsk_symbols.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigbee_frame_to_gfsk_symbols
// 802.15.4-style PHY frame encoder: payload bytes in, one 16-bit GFSK symbol
// word per nibble out, with chip-distance checks and a per-frame summary.
// ----------------------------------------------------------------------------
// Path: stage-1 register, then output register; a stall can hold the beat.
// Throughput: one symbol beat per cycle while the output is not stalled; a
//   payload beat gives 2 symbol beats, plus 2*PREAMBLE_BYTES+4 on the first
//   byte of a frame and 4 on the last (CRC); a bad-length beat gives 1. The
//   nibble sequencer sets these numbers. Reset: arst_n clears all control and
//   frame state at once; SFD returns to 0xA7. No clearing pass, the block takes beats right after reset.
// ----------------------------------------------------------------------------
module zigbee_frame_to_gfsk_symbols
	import zfg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sfd_we,
	input  logic [BYTE_W-1:0] sfd_wdata,
	zfg_in_if.sink            payload,
	zfg_out_if.source         symbols
);

	// SFD register; write it only while idle, the block does not enforce this
	logic [BYTE_W-1:0] sfd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sfd_q <= SFD_RESET;
		end else if (sfd_we) begin
			sfd_q <= sfd_wdata;
		end
	end

	// Sequencer -> encoder symbol request. The sequencer takes a new payload
	// beat on the cycle its last nibble goes over, so beats flow back to back.
	logic     req_valid;
	logic     req_ready;
	sym_req_t req;

	// Stage 1: holds the payload beat, frame state and CRC, and walks the
	// byte order of the beat: preamble zeros, SFD, PHR (length+2), data,
	// then CRC low/high on the last payload byte. Bad lengths become one
	// error request and leave the frame state untouched.
	zfg_frame_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sfd_value (sfd_q),
		.payload   (payload),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready)
	);

	// Stage 2: nibble -> symbol -> GFSK word, distance and match from
	// constant tables, running all-match/min/max, registered output. The
	// output register takes a new request while empty or as its beat leaves.
	zfg_sym_enc u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.symbols   (symbols)
	);

endmodule

// ===== rtl/core/zfg_frame_ctl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfg_frame_ctl
// Takes payload beats, tracks frame state and CRC, and walks each beat's byte
// sequence (preamble, SFD, PHR, data, CRC), a nibble a cycle unless stalled.
// ----------------------------------------------------------------------------
module zfg_frame_ctl
	import zfg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] sfd_value,
	zfg_in_if.sink            payload,
	output logic              req_valid,
	output sym_req_t          req,
	input  logic              req_ready
);

	localparam int PRE_CNT_W = $clog2(PREAMBLE_BYTES + 1);
	localparam logic [PRE_CNT_W-1:0] PRE_LAST = PRE_CNT_W'(PREAMBLE_BYTES - 1);

	typedef enum logic [6:0] {
		PH_PRE  = 7'b0000001,
		PH_SFD  = 7'b0000010,
		PH_PHR  = 7'b0000100,
		PH_DATA = 7'b0001000,
		PH_CRCL = 7'b0010000,
		PH_CRCH = 7'b0100000,
		PH_ERR  = 7'b1000000
	} phase_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	phase_t                phase_q;
	logic                  busy_s1;
	logic                  first_s1;
	logic                  last_s1;
	logic                  start_q;
	logic                  hi_q;
	logic [PRE_CNT_W-1:0]  pre_cnt_q;
	logic [BYTE_W-1:0]     byte_s1;
	logic [BYTE_W-1:0]     len_s1;
	logic [15:0]           crc_q;
	logic [LEFT_W-1:0]     left_q;
	logic                  in_frame_q;

	logic                  accept;
	logic                  fire;
	logic                  last_sym;
	logic                  done;
	logic                  is_first;
	logic                  is_bad;
	logic [LEFT_W-1:0]     new_left;
	logic [BYTE_W-1:0]     cur_byte;

	assign is_first = !in_frame_q;
	assign is_bad   = is_first && (payload.payload_length == '0 ||
		payload.payload_length > LEN_MAX);
	assign new_left = is_first ? (payload.payload_length[LEFT_W-1:0] - LEFT_W'(1))
		: (left_q - LEFT_W'(1));

	always_comb begin
		unique case (phase_q)
			PH_PRE:  cur_byte = '0;
			PH_SFD:  cur_byte = sfd_value;
			PH_PHR:  cur_byte = len_s1 + BYTE_W'(2);
			PH_DATA: cur_byte = byte_s1;
			PH_CRCL: cur_byte = crc_q[7:0];
			PH_CRCH: cur_byte = crc_q[15:8];
			PH_ERR:  cur_byte = '0;
			default: cur_byte = '0;
		endcase
	end

	assign last_sym = (phase_q == PH_ERR) ||
		(hi_q && ((phase_q == PH_DATA && !last_s1) || phase_q == PH_CRCH));

	assign req_valid     = busy_s1;
	assign req.err       = (phase_q == PH_ERR);
	assign req.first_sym = start_q;
	assign req.frame_end = (phase_q == PH_CRCH) && hi_q;
	assign req.nibble    = hi_q ? cur_byte[7:4] : cur_byte[3:0];

	assign fire          = req_valid && req_ready;
	assign done          = fire && last_sym;
	assign payload.ready = !busy_s1 || done;
	assign accept        = payload.valid && payload.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_PRE;
			busy_s1    <= 1'b0;
			first_s1   <= 1'b0;
			last_s1    <= 1'b0;
			start_q    <= 1'b0;
			hi_q       <= 1'b0;
			pre_cnt_q  <= '0;
			crc_q      <= '0;
			left_q     <= '0;
			in_frame_q <= 1'b0;
		end else if (accept) begin
			busy_s1   <= 1'b1;
			hi_q      <= 1'b0;
			pre_cnt_q <= '0;
			first_s1  <= is_first && !is_bad;
			start_q   <= is_first && !is_bad;
			last_s1   <= (new_left == '0);
			if (is_bad) begin
				phase_q <= PH_ERR;
			end else begin
				phase_q    <= is_first ? PH_PRE : PH_DATA;
				left_q     <= new_left;
				crc_q      <= crc_byte(is_first ? 16'd0 : crc_q, payload.payload_byte);
				in_frame_q <= (new_left != '0);
			end
		end else if (fire) begin
			hi_q    <= !hi_q;
			start_q <= 1'b0;
			if (done)
				busy_s1 <= 1'b0;
			if (hi_q) begin
				unique case (phase_q)
					PH_PRE: begin
						if (pre_cnt_q == PRE_LAST)
							phase_q <= PH_SFD;
						else
							pre_cnt_q <= pre_cnt_q + PRE_CNT_W'(1);
					end
					PH_SFD:  phase_q <= PH_PHR;
					PH_PHR:  phase_q <= PH_DATA;
					PH_DATA: if (last_s1) phase_q <= PH_CRCL;
					PH_CRCL: phase_q <= PH_CRCH;
					PH_CRCH: phase_q <= PH_CRCH;
					PH_ERR:  phase_q <= PH_ERR;
					default: phase_q <= PH_PRE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= payload.payload_byte;
			len_s1  <= payload.payload_length;
		end
	end

	// frame open exactly while payload bytes remain
	assert property (@(posedge clk) disable iff (!arst_n) in_frame_q == (left_q != '0))
		else $error("frame state and byte count disagree");

	// frame end only on an item of the beat carrying the last payload byte
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 && req.frame_end |-> last_s1)
		else $error("frame end on a non-final item");

	// frame start flag only on the very first preamble nibble
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 && start_q |-> first_s1 && phase_q == PH_PRE && !hi_q && pre_cnt_q == '0)
		else $error("frame start outside first preamble nibble");

endmodule

// ===== rtl/core/zfg_sym_enc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfg_sym_enc
// Maps a nibble to its symbol and GFSK word, keeps per-frame distance stats,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module zfg_sym_enc
	import zfg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  sym_req_t req,
	output logic     req_ready,
	zfg_out_if.source symbols
);

	logic              ov_q;
	logic              all_q;
	logic [DIST_W-1:0] min_q;
	logic [DIST_W-1:0] max_q;

	logic [WORD_W-1:0] word_q;
	logic [NIB_W-1:0]  sym_q;
	logic [DIST_W-1:0] dist_q;
	logic              match_q;
	logic              end_q;
	logic              ok_q;
	logic [DIST_W-1:0] dmin_q;
	logic [DIST_W-1:0] dmax_q;
	logic              status_q;

	logic              load;
	logic [NIB_W-1:0]  sym;
	logic [DIST_W-1:0] sym_dist;
	logic              match;
	logic              base_all;
	logic [DIST_W-1:0] base_min;
	logic [DIST_W-1:0] base_max;
	logic              new_all;
	logic [DIST_W-1:0] new_min;
	logic [DIST_W-1:0] new_max;

	assign req_ready = !ov_q || symbols.ready;
	assign load      = req_valid && req_ready;

	// nibble is read LSB first
	assign sym      = {req.nibble[0], req.nibble[1], req.nibble[2], req.nibble[3]};
	assign sym_dist = DIST_TABLE[sym];
	assign match    = MATCH_TABLE[sym];

	assign base_all = req.first_sym ? 1'b1 : all_q;
	assign base_min = req.first_sym ? DIST_INIT : min_q;
	assign base_max = req.first_sym ? '0 : max_q;
	assign new_all  = base_all && match;
	assign new_min  = (sym_dist < base_min) ? sym_dist : base_min;
	assign new_max  = (sym_dist > base_max) ? sym_dist : base_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			all_q <= 1'b1;
			min_q <= DIST_INIT;
			max_q <= '0;
		end else begin
			if (req_ready)
				ov_q <= req_valid;
			if (load && !req.err) begin
				all_q <= new_all;
				min_q <= new_min;
				max_q <= new_max;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (req.err) begin
				word_q   <= '0;
				sym_q    <= '0;
				dist_q   <= '0;
				match_q  <= 1'b0;
				end_q    <= 1'b1;
				ok_q     <= 1'b0;
				dmin_q   <= '0;
				dmax_q   <= '0;
				status_q <= STATUS_BAD_LEN;
			end else begin
				word_q   <= WORD_TABLE[sym];
				sym_q    <= sym;
				dist_q   <= sym_dist;
				match_q  <= match;
				end_q    <= req.frame_end;
				ok_q     <= req.frame_end && new_all;
				dmin_q   <= req.frame_end ? new_min : '0;
				dmax_q   <= req.frame_end ? new_max : '0;
				status_q <= STATUS_OK;
			end
		end
	end

	assign symbols.valid           = ov_q;
	assign symbols.gfsk_word       = word_q;
	assign symbols.zigbee_symbol   = sym_q;
	assign symbols.symbol_distance = dist_q;
	assign symbols.symbol_match    = match_q;
	assign symbols.frame_end       = end_q;
	assign symbols.frame_ok        = ok_q;
	assign symbols.frame_dist_min  = dmin_q;
	assign symbols.frame_dist_max  = dmax_q;
	assign symbols.status          = status_q;

	// frame summary spans the last symbol, so min never exceeds max
	assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && end_q && status_q == STATUS_OK |-> dmin_q <= dmax_q && dmin_q <= dist_q)
		else $error("frame distance summary inconsistent");

	// a stalled beat holds still
	assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !symbols.ready |=> ov_q && $stable(word_q) && $stable(end_q))
		else $error("symbol beat changed while stalled");

	// an error beat closes its frame and carries no word
	assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && status_q == STATUS_BAD_LEN |-> end_q && word_q == '0)
		else $error("error beat malformed");

endmodule

// ===== tb/tb_zigbee_frame_to_gfsk_symbols.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zigbee_frame_to_gfsk_symbols
// Self-checking bench for the frame to GFSK symbol encoder. Payload beats go
// in back to back or in bursts over valid/ready while the symbol side stalls on its
// own pattern. A scoreboard class rebuilds every symbol beat (preamble, SFD,
// PHR, payload, CRC) and its chip-distance data, and checks them in order.
// ----------------------------------------------------------------------------
module tb_zigbee_frame_to_gfsk_symbols;
	import zfg_pkg::*;

	// reflected CCITT polynomial, zero init
	localparam logic [15:0] CRC16_POLY_REFL = 16'h8408;

	// symbol -> 16-bit GFSK word, bit 0 goes out first
	localparam logic [WORD_W-1:0] GFSK_OF_SYM [NSYM] = '{
		16'h419F, 16'h0E77, 16'h999E, 16'h667A,
		16'h9DC3, 16'h770E, 16'hDC39, 16'h70E7,
		16'hBCF5, 16'hB3D7, 16'hCD5F, 16'h357F,
		16'hD5FC, 16'h57F3, 16'h5BCF, 16'h6F3D
	};

	// 32-chip PN sequences; chip 0 is the leftmost digit (bit 31)
	localparam logic [31:0] PN_CHIPS [NSYM] = '{
		32'b11011001110000110101001000101110,
		32'b11101101100111000011010100100010,
		32'b00101110110110011100001101010010,
		32'b00100010111011011001110000110101,
		32'b01010010001011101101100111000011,
		32'b00110101001000101110110110011100,
		32'b11000011010100100010111011011001,
		32'b10011100001101010010001011101101,
		32'b10001100100101100000011101111011,
		32'b10111000110010010110000001110111,
		32'b01111011100011001001011000000111,
		32'b01110111101110001100100101100000,
		32'b00000111011110111000110010010110,
		32'b01100000011101111011100011001001,
		32'b10010110000001110111101110001100,
		32'b11001001011000000111011110111000
	};

	// one symbol beat, field for field as on the output channel
	typedef struct packed {
		logic [WORD_W-1:0] gfsk_word;
		logic [NIB_W-1:0]  zigbee_symbol;
		logic [DIST_W-1:0] symbol_distance;
		logic              symbol_match;
		logic              frame_end;
		logic              frame_ok;
		logic [DIST_W-1:0] frame_dist_min;
		logic [DIST_W-1:0] frame_dist_max;
		logic              status;
	} sym_beat_t;

	// ------------------------------------------------------------------------
	// Scoreboard: encoder state mirror plus the queue of symbol beats owed.
	// ------------------------------------------------------------------------
	class frame_scoreboard;
		sym_beat_t         symbols_owed[$];
		logic [BYTE_W-1:0] sfd;
		bit                framing;
		logic [LEFT_W-1:0] bytes_left;
		logic [15:0]       crc;
		bit                all_match;
		logic [DIST_W-1:0] dist_lo;
		logic [DIST_W-1:0] dist_hi;
		int                failures;
		int                beats_in;
		int                frames_done;
		int                len_errors;
		int                beats_checked;

		function new();
			sfd           = SFD_RESET;
			framing       = 1'b0;
			bytes_left    = '0;
			crc           = '0;
			all_match     = 1'b1;
			dist_lo       = 6'd63;
			dist_hi       = '0;
			failures      = 0;
			beats_in      = 0;
			frames_done   = 0;
			len_errors    = 0;
			beats_checked = 0;
		endfunction

		function void set_sfd(logic [BYTE_W-1:0] v);
			sfd = v;
		endfunction

		function int pending();
			return symbols_owed.size();
		endfunction

		// nibble is read LSB first, so the symbol is its bit reversal
		function void owe_symbol(logic [NIB_W-1:0] nib);
			logic [NIB_W-1:0]  s;
			logic [WORD_W-1:0] w;
			int                d;
			int                best;
			int                best_ref;
			sym_beat_t         e;
			s        = {nib[0], nib[1], nib[2], nib[3]};
			w        = GFSK_OF_SYM[s];
			best     = 33;
			best_ref = 0;
			// each GFSK bit stands for two chips; first nearest wins ties
			for (int r = 0; r < NSYM; r++) begin
				d = 0;
				for (int c = 0; c < 32; c++) begin
					if (w[c >> 1] != PN_CHIPS[r][31 - c])
						d++;
				end
				if (d < best) begin
					best     = d;
					best_ref = r;
				end
			end
			if (best_ref != int'(s))
				all_match = 1'b0;
			if (best < int'(dist_lo))
				dist_lo = DIST_W'(best);
			if (best > int'(dist_hi))
				dist_hi = DIST_W'(best);
			e                 = '0;
			e.gfsk_word       = w;
			e.zigbee_symbol   = s;
			e.symbol_distance = DIST_W'(best);
			e.symbol_match    = (best_ref == int'(s));
			e.status          = STATUS_OK;
			symbols_owed.push_back(e);
		endfunction

		function void owe_byte(logic [BYTE_W-1:0] b);
			owe_symbol(b[3:0]);
			owe_symbol(b[7:4]);
		endfunction

		// payload beat accepted: queue every symbol beat it causes
		function void note_payload(logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] len);
			sym_beat_t e;
			beats_in++;
			if (!framing) begin
				if (len == 0 || int'(len) > MAX_PAYLOAD) begin
					e           = '0;
					e.frame_end = 1'b1;
					e.status    = STATUS_BAD_LEN;
					symbols_owed.push_back(e);
					len_errors++;
					return;
				end
				crc        = '0;
				all_match  = 1'b1;
				dist_lo    = 6'd63;
				dist_hi    = '0;
				bytes_left = len[LEFT_W-1:0];
				for (int i = 0; i < PREAMBLE_BYTES; i++)
					owe_byte(8'h00);
				owe_byte(sfd);
				owe_byte(len + 8'd2);
				framing = 1'b1;
			end
			owe_byte(b);
			crc = crc ^ {8'h00, b};
			for (int i = 0; i < 8; i++)
				crc = crc[0] ? ((crc >> 1) ^ CRC16_POLY_REFL) : (crc >> 1);
			bytes_left = bytes_left - 1'b1;
			if (bytes_left == 0) begin
				owe_byte(crc[7:0]);
				owe_byte(crc[15:8]);
				// frame summary rides on the last CRC symbol
				e                = symbols_owed.pop_back();
				e.frame_end      = 1'b1;
				e.frame_ok       = all_match;
				e.frame_dist_min = dist_lo;
				e.frame_dist_max = dist_hi;
				symbols_owed.push_back(e);
				framing = 1'b0;
				frames_done++;
			end
		endfunction

		function void cmp(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_beat(sym_beat_t got);
			sym_beat_t want;
			if (symbols_owed.size() == 0) begin
				$error("symbol beat with nothing owed: gfsk_word %h", got.gfsk_word);
				failures++;
				return;
			end
			want = symbols_owed.pop_front();
			beats_checked++;
			cmp("gfsk_word",       want.gfsk_word,       got.gfsk_word);
			cmp("zigbee_symbol",   want.zigbee_symbol,   got.zigbee_symbol);
			cmp("symbol_distance", want.symbol_distance, got.symbol_distance);
			cmp("symbol_match",    want.symbol_match,    got.symbol_match);
			cmp("frame_end",       want.frame_end,       got.frame_end);
			cmp("frame_ok",        want.frame_ok,        got.frame_ok);
			cmp("frame_dist_min",  want.frame_dist_min,  got.frame_dist_min);
			cmp("frame_dist_max",  want.frame_dist_max,  got.frame_dist_max);
			cmp("status",          want.status,          got.status);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, channels and the block
	// ------------------------------------------------------------------------
	logic              clk;
	logic              arst_n;
	logic              sfd_we;
	logic [BYTE_W-1:0] sfd_wdata;

	zfg_in_if  payload_ch ();
	zfg_out_if symbol_ch ();

	zigbee_frame_to_gfsk_symbols dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sfd_we    (sfd_we),
		.sfd_wdata (sfd_wdata),
		.payload   (payload_ch),
		.symbols   (symbol_ch)
	);

	frame_scoreboard sb = new();

	// sender pacing: burst length left and the widest gap in this phase
	int burst_left;
	int gap_max;
	// main thread asks, the receiver process does the counting
	bit long_hold_req;

	sym_beat_t seen_beat;
	assign seen_beat = {symbol_ch.gfsk_word, symbol_ch.zigbee_symbol,
		symbol_ch.symbol_distance, symbol_ch.symbol_match, symbol_ch.frame_end,
		symbol_ch.frame_ok, symbol_ch.frame_dist_min, symbol_ch.frame_dist_max,
		symbol_ch.status};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit: far above the slowest legal run (every beat 18 symbols,
	// receiver mostly stalled, full sender gaps).
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Monitors. Everything is sampled at the rising edge, before the block's
	// own updates land; all stimulus moves on the falling edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (payload_ch.valid === 1'b1 && payload_ch.ready === 1'b1)
				sb.note_payload(payload_ch.payload_byte, payload_ch.payload_length);
			if (symbol_ch.valid === 1'b1 && symbol_ch.ready === 1'b1)
				sb.check_beat(seen_beat);
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: its own stall pattern. Modes last a random stretch: always
	// ready, coin flip, one cycle in four, mostly ready. A hold request
	// parks ready low for a long stretch so the block backs up into the
	// payload side.
	// ------------------------------------------------------------------------
	initial begin
		int mode;
		int left;
		int hold;
		symbol_ch.ready = 1'b0;
		mode = 0;
		left = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = 300;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			if (hold > 0) begin
				hold--;
				symbol_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: begin
						symbol_ch.ready <= 1'b1;
					end
					1: begin
						symbol_ch.ready <= 1'($urandom_range(0, 1));
					end
					2: begin
						symbol_ch.ready <= (left % 4 == 0);
					end
					default: begin
						symbol_ch.ready <= ($urandom_range(0, 9) != 0);
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender tasks
	// ------------------------------------------------------------------------

	// valid drops for an idle stretch whose length n sets; data lines wander meanwhile
	task automatic idle(input int n);
		repeat (n) begin
			@(negedge clk);
			payload_ch.valid          <= 1'b0;
			payload_ch.payload_byte   <= 8'($urandom);
			payload_ch.payload_length <= 8'($urandom);
		end
	endtask

	// Offer one beat and hold it until taken. valid stays up into the next
	// beat, so it is written once per falling edge at most.
	task automatic send_beat(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] len);
		@(negedge clk);
		payload_ch.valid          <= 1'b1;
		payload_ch.payload_byte   <= b;
		payload_ch.payload_length <= len;
		do
			@(posedge clk);
		while (payload_ch.ready !== 1'b1);
		if (gap_max != 0) begin
			burst_left--;
			if (burst_left <= 0) begin
				idle($urandom_range(1, gap_max));
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	// length goes on the first beat only; later ones carry junk there
	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++)
			send_beat(8'($urandom), (i == 0) ? 8'(len) : 8'($urandom));
	endtask

	// stop offering until every owed symbol beat is out, then settle
	task automatic drain();
		idle(1);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_sfd(input logic [BYTE_W-1:0] v);
		@(negedge clk);
		sfd_we    <= 1'b1;
		sfd_wdata <= v;
		@(negedge clk);
		sfd_we    <= 1'b0;
		sb.set_sfd(v);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [BYTE_W-1:0] nib_walk [8];
		int                phase_start;
		int                r;
		payload_ch.valid          = 1'b0;
		payload_ch.payload_byte   = '0;
		payload_ch.payload_length = '0;
		sfd_we                    = 1'b0;
		sfd_wdata                 = '0;
		arst_n                    = 1'b0;
		long_hold_req             = 1'b0;
		burst_left                = 1;
		gap_max                   = 0;
		// low nibbles 0,2,..,E and high 1,3,..,F: all sixteen symbols
		nib_walk = '{8'h10, 8'h32, 8'h54, 8'h76, 8'h98, 8'hBA, 8'hDC, 8'hFE};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset SFD. Bad lengths first: zero, one past the
		// max, all ones; each must give one error beat and leave it idle.
		send_beat(8'hFF, 8'd0);
		send_beat(8'h00, 8'(MAX_PAYLOAD + 1));
		send_beat(8'h5A, 8'hFF);
		// one-byte frames: the most symbol beats a single input can cause
		send_beat(8'h00, 8'd1);
		send_beat(8'hFF, 8'd1);
		// every symbol once; inner lengths of 0 and all ones must be ignored
		for (int i = 0; i < 8; i++)
			send_beat(nib_walk[i], (i == 0) ? 8'd8 : ((i % 2) ? 8'h00 : 8'hFF));
		send_beat(8'h80, 8'd3);
		send_beat(8'h01, 8'h00);
		send_beat(8'h7F, 8'h80);
		drain();

		// Random phases. Each one runs under its own SFD (reset value, then
		// both extremes and two random picks); odd phases pace the sender in
		// bursts, even ones offer back to back.
		for (int p = 0; p < 5; p++) begin
			if (p == 1)
				write_sfd(8'h00);
			else if (p == 2)
				write_sfd(8'hFF);
			else if (p > 2)
				write_sfd(8'($urandom));
			gap_max     = (p % 2) ? 8 : 0;
			burst_left  = $urandom_range(1, 12);
			phase_start = sb.beats_in;

			// longest legal frame once
			if (p == 1) begin
				send_frame(MAX_PAYLOAD);
				drain();
			end

			// receiver holds off while beats keep coming: the block fills up
			// and must push back on the payload side
			if (p == 2) begin
				long_hold_req = 1'b1;
				send_frame(20);
				drain();
			end

			while (sb.beats_in - phase_start < 75) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					send_beat(8'($urandom), ($urandom_range(0, 2) == 0) ?
						8'd0 : 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
				else if (r < 88)
					send_frame($urandom_range(1, 6));
				else
					send_frame($urandom_range(7, 24));
				if ($urandom_range(0, 9) == 0)
					drain();
			end
			drain();
		end

		idle(1);
		while (sb.pending() != 0)
			@(posedge clk);
		// catch anything extra the block might still put out
		repeat (20) @(posedge clk);

		$display("Run covered %0d payload beats: %0d frames, %0d bad lengths.",
			sb.beats_in, sb.frames_done, sb.len_errors);
		$display("%0d symbol beats checked under five SFD settings.", sb.beats_checked);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
